// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker file.
// Holds clocked implication checks only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define CHK_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// Check that a condition implies a consequence on the next edge.
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

// ===== design/dhfk_pkg.sv =====
// Shared types, constants and helpers for the DH forward-kinematics chain.
// No dependencies.
package dhfk_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CORDIC_ITERS   = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int QUEUE_DEPTH    = 2;

  // CORDIC arctangent table, 2^32 per turn
  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/dhfk_front.sv =====
// Front end: accepts joint beats and queues them for the back end.
// Depends on dhfk_pkg.
module dhfk_front #(
  parameter int ANGLE_BITS = dhfk_pkg::ANGLE_BITS_DEF,
  parameter int DEPTH      = dhfk_pkg::QUEUE_DEPTH,
  localparam int QW        = 1 + 2 * ANGLE_BITS + 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [QW-1:0] in_item,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [QW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  // store entering beats
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== design/dhfk_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation a cycle.
// Depends on dhfk_pkg.
module dhfk_cordic #(
  parameter int ANGLE_BITS = dhfk_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = dhfk_pkg::FRAC_BITS_DEF,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output logic signed [RW-1:0]  cos_o,
  output logic signed [RW-1:0]  sin_o
);
  logic [31:0] phase;
  logic signed [33:0] x, y, z;
  logic [4:0] iter;
  logic busy;
  logic [1:0] quad;
  logic signed [33:0] xs, ys, xr, yr, one, mone;
  logic signed [RW-1:0] xc, yc;

  assign phase = {angle, {(32-ANGLE_BITS){1'b0}}};
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign one  = 34'sd1 <<< FRAC_BITS;
  assign mone = -one;

  // round to Q1.FRAC and clamp
  always_comb begin
    xr = (x + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    yr = (y + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    xc = (xr > one) ? RW'(one) : (xr < mone) ? RW'(mone) : RW'(xr);
    yc = (yr > one) ? RW'(one) : (yr < mone) ? RW'(mone) : RW'(yr);
    case (quad)
      2'd0: begin cos_o = xc;  sin_o = yc;  end
      2'd1: begin cos_o = -yc; sin_o = xc;  end
      2'd2: begin cos_o = -xc; sin_o = -yc; end
      default: begin cos_o = yc; sin_o = -xc; end
    endcase
  end

  // iterate micro-rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        quad <= phase[31:30];
        x <= dhfk_pkg::CORDIC_GAIN;
        y <= '0;
        z <= {4'b0, phase[29:0]};
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - ys; y <= y + xs; z <= z - dhfk_pkg::atan_lut(iter);
        end else begin
          x <= x + ys; y <= y - xs; z <= z + dhfk_pkg::atan_lut(iter);
        end
        iter <= iter + 5'd1;
        if (iter == 5'(dhfk_pkg::CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/dhfk_back.sv =====
// Back end: builds the local transform and folds it into the chain,
// one multiply a cycle on a shared multiplier. Depends on dhfk_pkg, dhfk_cordic.
module dhfk_back #(
  parameter int ANGLE_BITS = dhfk_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = dhfk_pkg::FRAC_BITS_DEF,
  localparam int QW        = 1 + 2 * ANGLE_BITS + 64,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [QW-1:0]        q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RW-1:0] rot_o [9],
  output logic signed [31:0]   pos_o [3]
);
  localparam logic [2:0] S_IDLE = 3'd0, S_C1 = 3'd1, S_C2 = 3'd2, S_LOC = 3'd3,
                         S_DOT = 3'd4, S_OUT = 3'd5;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

  logic [2:0] state;
  logic signed [RW-1:0] cr [9];
  logic signed [31:0]   cp [3];
  logic signed [RW-1:0] cr_n [9];
  logic signed [31:0]   cp_n [3];
  logic signed [RW-1:0] lr [9];
  logic signed [31:0]   lp [3];
  logic signed [RW-1:0] ct, st, ca, sa;
  logic [QW-1:0] item;
  logic [3:0] step;
  logic [1:0] term;
  logic signed [63:0] acc;
  logic c_start, c_done;
  logic [ANGLE_BITS-1:0] c_angle;
  logic signed [RW-1:0] c_cos, c_sin;
  logic signed [RW+31:0] prod;
  logic signed [RW-1:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] rnd, sum;
  logic [1:0] row;
  logic [1:0] col;

  assign c_angle = (state == S_IDLE) ? q_item[QW-2 -: ANGLE_BITS] : item[64 +: ANGLE_BITS];
  assign c_start = (state == S_IDLE && q_valid) || (state == S_C1 && c_done);
  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign rot_o = cr;
  assign pos_o = cp;
  assign row = 2'(step / 4);
  assign col = 2'(step % 4);

  dhfk_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk, .rst, .start(c_start), .angle(c_angle), .done(c_done),
    .cos_o(c_cos), .sin_o(c_sin));

  // select multiplier operands: local products first, then dot products
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_LOC) begin
      case (step)
        4'd0: begin ma = st; mb = 32'(ca); end
        4'd1: begin ma = ct; mb = 32'(ca); end
        4'd2: begin ma = st; mb = 32'(sa); end
        4'd3: begin ma = ct; mb = 32'(sa); end
        4'd4: begin ma = sa; mb = $signed(item[63:32]); end
        default: begin ma = ca; mb = $signed(item[63:32]); end
      endcase
    end else begin
      ma = cr[4'(row) * 4'd3 + 4'(term)];
      mb = (col == 2'd3) ? lp[term] : 32'(lr[4'(term) * 4'd3 + 4'(col)]);
    end
  end
  assign prod = ma * mb;
  assign sum  = acc + 64'(prod);
  assign rnd  = (sum + HALF) >>> FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) ? 32'h7fffffff :
           (v < -64'sd2147483648) ? 32'h80000000 : v[31:0];
  endfunction
  function automatic logic signed [RW-1:0] satr(input logic signed [63:0] v);
    return (v > ONE) ? RW'(ONE) : (v < -ONE) ? RW'(-ONE) : RW'(v);
  endfunction

  // sequence one joint
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < 9; k++) cr[k] <= (k % 4 == 0) ? RW'(ONE) : '0;
      for (int k = 0; k < 3; k++) cp[k] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          item <= q_item;
          if (q_item[QW-1]) begin
            for (int k = 0; k < 9; k++) cr[k] <= (k % 4 == 0) ? RW'(ONE) : '0;
            for (int k = 0; k < 3; k++) cp[k] <= '0;
          end
          state <= S_C1;
        end
        S_C1: if (c_done) begin
          ct <= c_cos; st <= c_sin;
          state <= S_C2;
        end
        S_C2: if (c_done) begin
          ca <= c_cos; sa <= c_sin;
          lr[0] <= ct; lr[1] <= -st; lr[2] <= '0;
          lr[5] <= -c_sin; lr[8] <= c_cos;
          lp[0] <= $signed(item[31:0]);
          step <= '0; acc <= '0;
          state <= S_LOC;
        end
        S_LOC: begin
          case (step)
            4'd0: lr[3] <= RW'(rnd);
            4'd1: lr[4] <= RW'(rnd);
            4'd2: lr[6] <= RW'(rnd);
            4'd3: lr[7] <= RW'(rnd);
            4'd4: lp[1] <= sat32(-rnd);
            default: lp[2] <= sat32(rnd);
          endcase
          if (step == 4'd5) begin
            step <= '0; term <= '0; state <= S_DOT;
          end else step <= step + 4'd1;
        end
        S_DOT: begin
          if (term == 2'd2) begin
            acc <= '0;
            term <= '0;
            if (col == 2'd3) cp_n[row] <= sat32(64'(cp[row]) + rnd);
            else cr_n[4'(row) * 4'd3 + 4'(col)] <= satr(rnd);
            if (step == 4'd11) state <= S_OUT;
            step <= step + 4'd1;
          end else begin
            acc <= sum;
            term <= term + 2'd1;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      // commit the new frame; the last origin component is finished this cycle
      if (state == S_DOT && term == 2'd2 && step == 4'd11) begin
        for (int k = 0; k < 9; k++) cr[k] <= cr_n[k];
        for (int k = 0; k < 3; k++) cp[k] <= (k == 2) ? sat32(64'(cp[2]) + rnd) : cp_n[k];
      end
    end
  end
endmodule

// ===== design/dh_forward_kinematics_chain.sv =====
// Top level of the modified-DH forward-kinematics chain.
// Depends on dhfk_pkg, dhfk_front, dhfk_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one joint per beat: flag,
//   joint angle, offset, twist, link length and link offset.
//   Output channel (out_valid/out_ready) carries the cumulative rotation
//   and origin after that joint; the last joint gives the tool pose.
//   Each joint takes two 24-step CORDIC runs on one shared CORDIC unit,
//   six local multiplies and 36 multiply-accumulate steps on one shared
//   multiplier, then the result handshake. The back end takes a new joint
//   only after its last result has been taken.
//   A two-entry queue in front accepts joints until full while the back end
//   works or the receiver stalls; the result stays on the ports until taken.
//   Reset sets the chain to identity rotation and zero origin and empties
//   the queue; first_joint restarts the chain the same way.
//
module dh_forward_kinematics_chain #(
  parameter int ANGLE_BITS = dhfk_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = dhfk_pkg::FRAC_BITS_DEF,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic first_joint,
  input  logic signed [15:0] joint_angle,
  input  logic signed [15:0] angle_offset,
  input  logic signed [15:0] twist_angle,
  input  logic signed [31:0] link_length,
  input  logic signed [31:0] link_offset,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [RW-1:0] rot_00, rot_01, rot_02,
  output logic signed [RW-1:0] rot_10, rot_11, rot_12,
  output logic signed [RW-1:0] rot_20, rot_21, rot_22,
  output logic signed [31:0] pos_x, pos_y, pos_z
);
  localparam int QW = 1 + 2 * ANGLE_BITS + 64;
  logic [QW-1:0] in_item, q_item;
  logic q_valid, q_ready;
  logic signed [RW-1:0] rot [9];
  logic signed [31:0] pos [3];

  // pack the joint beat, wrapping theta to one turn
  assign in_item = {first_joint,
                    ANGLE_BITS'(joint_angle) + ANGLE_BITS'(angle_offset),
                    ANGLE_BITS'(twist_angle), link_offset, link_length};

  dhfk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item);

  dhfk_back #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .rot_o(rot), .pos_o(pos));

  assign {rot_00, rot_01, rot_02} = {rot[0], rot[1], rot[2]};
  assign {rot_10, rot_11, rot_12} = {rot[3], rot[4], rot[5]};
  assign {rot_20, rot_21, rot_22} = {rot[6], rot[7], rot[8]};
  assign {pos_x, pos_y, pos_z} = {pos[0], pos[1], pos[2]};
endmodule

// ===== design/dhfk_checker.sv =====
// Port-level checker for the forward-kinematics chain, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dhfk_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] pos_x
);
  // a result waiting on the port holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pos_x))
  // no result beat straight after another
  `CHK_NEXT(a_out_gap, clk, rst, out_valid && out_ready, !out_valid)
  // queue is free again after reset
  `CHK_NEXT(a_rst_ready, clk, 1'b0, rst, in_ready)
endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .pos_x);

// ===== sim/dh_forward_kinematics_chain_checker.sv =====
// Checker for the DH forward-kinematics chain: watches both channels,
// predicts each pose from the accepted joint beats and compares field by field.
// Depends on nothing outside this file.
module dh_forward_kinematics_chain_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic first_joint,
  input  logic signed [15:0] joint_angle,
  input  logic signed [15:0] angle_offset,
  input  logic signed [15:0] twist_angle,
  input  logic signed [31:0] link_length,
  input  logic signed [31:0] link_offset,
  input  logic out_valid,
  input  logic out_ready,
  input  logic signed [17:0] rot_00, rot_01, rot_02,
  input  logic signed [17:0] rot_10, rot_11, rot_12,
  input  logic signed [17:0] rot_20, rot_21, rot_22,
  input  logic signed [31:0] pos_x, pos_y, pos_z,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd65536;

  typedef struct {
    logic signed [17:0] rot [9];
    logic signed [31:0] pos [3];
  } pose_t;

  longint frame_rot [9];
  longint frame_pos [3];
  pose_t pose_q [$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_frac(longint v);
    return floor_shift(v + 64'sd32768, 16);
  endfunction

  function automatic longint sat_word(longint v);
    return lim(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // CORDIC sine and cosine of a 16-bit binary angle, Q1.16
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    longint atans [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    logic [31:0] ph;
    longint x, y, z, t;
    ph = {ang, 16'h0};
    z = longint'(ph[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= atans[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += atans[i];
      end
      x = t;
    end
    x = lim((x + 64'sd8192) >>> 14, -ONE, ONE);
    y = lim((y + 64'sd8192) >>> 14, -ONE, ONE);
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic restart_frame();
    for (int k = 0; k < 9; k++) frame_rot[k] = (k % 4 == 0) ? ONE : 0;
    for (int k = 0; k < 3; k++) frame_pos[k] = 0;
  endtask

  // Apply one joint to the running frame and queue the pose it gives
  task automatic apply_joint();
    longint ct, st, ca, sa, acc, d;
    longint lr [9];
    longint lp [3];
    longint nr [9];
    longint np [3];
    logic [15:0] th;
    pose_t p;
    if (first_joint) restart_frame();
    th = joint_angle + angle_offset;
    sin_cos(th, ct, st);
    sin_cos(twist_angle, ca, sa);
    d = link_offset;
    lr = '{ct, -st, 0, round_frac(st * ca), round_frac(ct * ca), -sa,
           round_frac(st * sa), round_frac(ct * sa), ca};
    lp = '{longint'(link_length), sat_word(-round_frac(sa * d)), sat_word(round_frac(ca * d))};
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        acc = frame_rot[r*3] * lr[k] + frame_rot[r*3+1] * lr[3+k]
            + frame_rot[r*3+2] * lr[6+k];
        nr[r*3+k] = lim(round_frac(acc), -ONE, ONE);
      end
      acc = frame_rot[r*3] * lp[0] + frame_rot[r*3+1] * lp[1] + frame_rot[r*3+2] * lp[2];
      np[r] = sat_word(frame_pos[r] + round_frac(acc));
    end
    for (int k = 0; k < 9; k++) begin
      frame_rot[k] = nr[k];
      p.rot[k] = nr[k][17:0];
    end
    for (int k = 0; k < 3; k++) begin
      frame_pos[k] = np[k];
      p.pos[k] = np[k][31:0];
    end
    pose_q.push_back(p);
  endtask

  // Compare one output beat against the oldest predicted pose
  task automatic check_pose();
    pose_t e;
    logic signed [17:0] got_r [9];
    logic signed [31:0] got_p [3];
    got_r = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
    got_p = '{pos_x, pos_y, pos_z};
    if (pose_q.size() == 0) begin
      $display("%0t: output beat with no pose expected", $time);
      errors++;
      return;
    end
    e = pose_q.pop_front();
    for (int k = 0; k < 9; k++)
      if (got_r[k] !== e.rot[k]) begin
        $display("%0t: rot[%0d] expected %0d actual %0d", $time, k, e.rot[k], got_r[k]);
        errors++;
      end
    for (int k = 0; k < 3; k++)
      if (got_p[k] !== e.pos[k]) begin
        $display("%0t: pos[%0d] expected %0d actual %0d", $time, k, e.pos[k], got_p[k]);
        errors++;
      end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    restart_frame();
  end

  // Sample both channels on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_frame();
      pose_q.delete();
    end else begin
      if (out_valid && out_ready) check_pose();
      if (in_valid && in_ready) apply_joint();
    end
    pending <= pose_q.size();
  end
endmodule

// ===== sim/dh_forward_kinematics_chain_test.sv =====
// Testbench top for the DH forward-kinematics chain: drives joint beats with
// random gaps and stalls and gives the verdict. Depends on the block
// and dh_forward_kinematics_chain_checker.
module dh_forward_kinematics_chain_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_JOINTS = 1430;
  localparam int CYCLE_LIMIT   = 900000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic first_joint = 0;
  logic signed [15:0] joint_angle = 0, angle_offset = 0, twist_angle = 0;
  logic signed [31:0] link_length = 0, link_offset = 0;
  logic signed [17:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [17:0] rot_20, rot_21, rot_22;
  logic signed [31:0] pos_x, pos_y, pos_z;
  int errors, pending, cycles = 0;
  bit calm = 0, hold_off = 0;

  dh_forward_kinematics_chain dut (.*);
  dh_forward_kinematics_chain_checker checker_i (.*);

  initial forever #1 clk = ~clk;

  // Abort on a runaway run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none late on
  initial begin
    int n;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
        held = 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_joint(bit f, logic [15:0] q, logic [15:0] off, logic [15:0] tw,
                            logic [31:0] a, logic [31:0] d);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    first_joint <= f;
    joint_angle <= q;
    angle_offset <= off;
    twist_angle <= tw;
    link_length <= a;
    link_offset <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
    endcase
  endfunction

  function automatic logic [15:0] rand_ang();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int n;
    repeat (12) @(negedge clk);
    rst <= 0;
    // Directed: building on reset, extremes, angle wrap, saturation
    send_joint(0, 16'h0000, 16'h0000, 16'h0000, 32'h00010000, 32'h00020000);
    send_joint(0, 16'h7fff, 16'h7fff, 16'h4000, 32'h7fffffff, 32'h7fffffff);
    send_joint(0, 16'h8000, 16'h8000, 16'hc000, 32'h80000000, 32'h80000000);
    send_joint(0, 16'h7fff, 16'h0001, 16'h8000, 32'h7fffffff, 32'h7fffffff);
    send_joint(0, 16'hffff, 16'hffff, 16'h7fff, 32'hffffffff, 32'h00000001);
    send_joint(1, 16'h4000, 16'hc000, 16'h2000, 32'h7fffffff, 32'h80000000);
    send_joint(0, 16'h2000, 16'h2000, 16'he000, 32'h7fffffff, 32'h7fffffff);
    send_joint(0, 16'h0000, 16'h4000, 16'h4000, 32'h7fffffff, 32'h7fffffff);
    send_joint(1, 16'h1234, 16'hedcc, 16'h0000, 32'h00000000, 32'h00000000);
    send_joint(0, 16'h5555, 16'haaaa, 16'h8001, 32'h80000000, 32'h7fffffff);
    // Random chains of one to seven joints, with a long stall early on
    for (int i = 0; i < RANDOM_JOINTS; ) begin
      n = $urandom_range(1, 7);
      if (i >= 40 && i < 47) hold_off = 1;
      if (i > RANDOM_JOINTS - 150) calm = 1;
      for (int j = 0; j < n; j++) begin
        send_joint(j == 0 ? $urandom_range(0, 7) != 0 : $urandom_range(0, 15) == 0,
                   rand_ang(), rand_ang(), rand_ang(), rand_len(), rand_len());
        i++;
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
